### design/lesu_pkg.sv
// Package for the log event statistics unit: item types, widths and level codes.
package lesu_pkg;

  // Ring depth and the widths that follow from it.
  localparam int unsigned WindowDepth = 1024;
  localparam int unsigned IdxW        = $clog2(WindowDepth);
  localparam int unsigned FillW       = $clog2(WindowDepth + 1);

  // Fixed field widths.
  localparam int unsigned CountW   = 32;
  localparam int unsigned LenW     = 16;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned SumW     = 48;
  localparam int unsigned WinCntW  = 11;
  localparam int unsigned QuoCntW  = $clog2(LenW + 1);

  // Window width after reset, in seconds.
  localparam logic [TimeW-1:0] WindowReset = 32'd3600;

  // Severity codes.
  localparam logic [1:0] LvlInfo  = 2'd0;
  localparam logic [1:0] LvlWarn  = 2'd1;
  localparam logic [1:0] LvlError = 2'd2;

  // One input item.
  typedef struct packed {
    logic [1:0]       level;
    logic [LenW-1:0]  message_length;
    logic [TimeW-1:0] timestamp;
  } event_t;

  // One result item.
  typedef struct packed {
    logic [CountW-1:0]  info_count;
    logic [CountW-1:0]  warn_count;
    logic [CountW-1:0]  error_count;
    logic [CountW-1:0]  total_count;
    logic [WinCntW-1:0] window_count;
    logic               window_overflow;
    logic [LenW-1:0]    longest;
    logic [LenW-1:0]    shortest;
    logic [LenW-1:0]    mean_length;
  } result_t;

  // Running statistics held by the stats block.
  typedef struct packed {
    logic [CountW-1:0] info_count;
    logic [CountW-1:0] warn_count;
    logic [CountW-1:0] error_count;
    logic [CountW-1:0] total_count;
    logic [SumW-1:0]   length_sum;
    logic [LenW-1:0]   longest;
    logic [LenW-1:0]   shortest;
  } stats_t;

  // Status of the timestamp ring.
  typedef struct packed {
    logic             done;
    logic             overflow;
    logic [FillW-1:0] fill;
  } ring_stat_t;

  // Status of the serial divider.
  typedef struct packed {
    logic            done;
    logic [LenW-1:0] quotient;
  } div_stat_t;

endpackage

### design/lesu_stats.sv
// Saturating level counters, running total and length sum, maximum and minimum.
module lesu_stats (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              upd_i,
  input  lesu_pkg::event_t  item_i,
  output lesu_pkg::stats_t  stats_o
);
  import lesu_pkg::*;

  logic [CountW-1:0] cnt_q [3];
  logic [CountW-1:0] cnt_d [3];
  logic [CountW-1:0] total_q, total_d;
  logic [SumW-1:0]   sum_q, sum_d;
  logic [LenW-1:0]   max_q, max_d;
  logic [LenW-1:0]   min_q, min_d;
  logic [SumW:0]     sum_ext;
  logic              bump;

  // Update on each accepted item; the total tracks the saturated sum of counters.
  always_comb begin
    bump    = 1'b0;
    sum_ext = {1'b0, sum_q} + (SumW+1)'(item_i.message_length);
    for (int i = 0; i < 3; i++) begin
      cnt_d[i] = cnt_q[i];
      if (upd_i && item_i.level == 2'(i) && cnt_q[i] != '1) begin
        cnt_d[i] = cnt_q[i] + CountW'(1);
        bump     = 1'b1;
      end
    end
    total_d = total_q;
    if (bump && total_q != '1) begin
      total_d = total_q + CountW'(1);
    end
    sum_d = sum_q;
    max_d = max_q;
    min_d = min_q;
    if (upd_i) begin
      sum_d = sum_ext[SumW] ? '1 : sum_ext[SumW-1:0];
      if (item_i.message_length > max_q) begin
        max_d = item_i.message_length;
      end
      if (item_i.message_length < min_q) begin
        min_d = item_i.message_length;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        cnt_q[i] <= '0;
      end
      total_q <= '0;
      sum_q   <= '0;
      max_q   <= '0;
      min_q   <= '1;
    end else begin
      for (int i = 0; i < 3; i++) begin
        cnt_q[i] <= cnt_d[i];
      end
      total_q <= total_d;
      sum_q   <= sum_d;
      max_q   <= max_d;
      min_q   <= min_d;
    end
  end

  assign stats_o.info_count  = cnt_q[LvlInfo];
  assign stats_o.warn_count  = cnt_q[LvlWarn];
  assign stats_o.error_count = cnt_q[LvlError];
  assign stats_o.total_count = total_q;
  assign stats_o.length_sum  = sum_q;
  assign stats_o.longest     = max_q;
  assign stats_o.shortest    = min_q;

endmodule

### design/lesu_ring.sv
// Timestamp ring in a memory, with push and a sequential window pop loop.
module lesu_ring (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [lesu_pkg::TimeW-1:0]  ts_i,
  input  logic [lesu_pkg::TimeW-1:0]  window_i,
  output lesu_pkg::ring_stat_t        stat_o
);
  import lesu_pkg::*;

  typedef enum logic [2:0] {
    R_IDLE = 3'b001,
    R_READ = 3'b010,
    R_CMP  = 3'b100
  } ring_state_e;

  ring_state_e       state_q, state_d;
  logic [IdxW-1:0]   head_q, head_d;
  logic [FillW-1:0]  fill_q, fill_d;
  logic [TimeW-1:0]  newest_q, newest_d;
  logic              ovf_q, ovf_d;
  logic              done_q, done_d;
  logic [TimeW-1:0]  rd_q;
  logic [TimeW-1:0]  ring_mem [WindowDepth];

  logic              full;
  logic [IdxW-1:0]   head_inc;
  logic [IdxW-1:0]   push_head;
  logic [IdxW-1:0]   push_off;
  logic [IdxW:0]     slot_sum;
  logic [IdxW-1:0]   wr_addr;
  logic              wr_en;
  logic [TimeW-1:0]  age;

  // Address arithmetic modulo the ring depth.
  always_comb begin
    full      = (fill_q == FillW'(WindowDepth));
    head_inc  = (head_q == IdxW'(WindowDepth - 1)) ? '0 : head_q + IdxW'(1);
    push_head = full ? head_inc : head_q;
    push_off  = full ? IdxW'(fill_q - FillW'(1)) : IdxW'(fill_q);
    slot_sum  = {1'b0, push_head} + {1'b0, push_off};
    if (slot_sum >= (IdxW+1)'(WindowDepth)) begin
      wr_addr = IdxW'(slot_sum - (IdxW+1)'(WindowDepth));
    end else begin
      wr_addr = slot_sum[IdxW-1:0];
    end
    age = newest_q - rd_q;
  end

  // Push on start, then read the oldest entry and drop it while it is too old.
  always_comb begin
    state_d  = state_q;
    head_d   = head_q;
    fill_d   = fill_q;
    newest_d = newest_q;
    ovf_d    = ovf_q;
    done_d   = 1'b0;
    wr_en    = 1'b0;
    unique case (state_q)
      R_IDLE: begin
        if (start_i) begin
          wr_en    = 1'b1;
          ovf_d    = full;
          head_d   = push_head;
          fill_d   = full ? fill_q : fill_q + FillW'(1);
          newest_d = ts_i;
          state_d  = R_READ;
        end
      end
      R_READ: begin
        if (fill_q > FillW'(1)) begin
          state_d = R_CMP;
        end else begin
          done_d  = 1'b1;
          state_d = R_IDLE;
        end
      end
      R_CMP: begin
        if (age >= window_i) begin
          head_d  = head_inc;
          fill_d  = fill_q - FillW'(1);
          state_d = R_READ;
        end else begin
          done_d  = 1'b1;
          state_d = R_IDLE;
        end
      end
      default: state_d = R_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= R_IDLE;
      head_q  <= '0;
      fill_q  <= '0;
      ovf_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      fill_q  <= fill_d;
      ovf_q   <= ovf_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    newest_q <= newest_d;
  end

  // Ring storage: one write port at the tail, registered read at the head.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      ring_mem[wr_addr] <= ts_i;
    end
    rd_q <= ring_mem[head_q];
  end

  assign stat_o.done     = done_q;
  assign stat_o.overflow = ovf_q;
  assign stat_o.fill     = fill_q;

endmodule

### design/lesu_div.sv
// Bit-serial restoring divider giving a saturated 16-bit quotient of sum by count.
module lesu_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [lesu_pkg::SumW-1:0]   dividend_i,
  input  logic [lesu_pkg::CountW-1:0] divisor_i,
  output lesu_pkg::div_stat_t         stat_o
);
  import lesu_pkg::*;

  logic [CountW-1:0]  rem_q, rem_d;
  logic [LenW-1:0]    dvd_q, dvd_d;
  logic [CountW-1:0]  dsr_q, dsr_d;
  logic [LenW-1:0]    quo_q, quo_d;
  logic [QuoCntW-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [CountW+1:0]  diff;
  logic               ge;

  // One quotient bit per cycle; the upper dividend part is checked for overflow first.
  always_comb begin
    diff   = {1'b0, rem_q, dvd_q[LenW-1]} - {2'b00, dsr_q};
    ge     = ~diff[CountW+1];
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    dsr_d  = dsr_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d = dividend_i[SumW-1:LenW];
      dvd_d = dividend_i[LenW-1:0];
      dsr_d = divisor_i;
      if (dividend_i[SumW-1:LenW] >= divisor_i) begin
        quo_d  = '1;
        done_d = 1'b1;
      end else begin
        quo_d  = '0;
        cnt_d  = QuoCntW'(LenW);
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      rem_d = ge ? diff[CountW-1:0] : {rem_q[CountW-2:0], dvd_q[LenW-1]};
      dvd_d = {dvd_q[LenW-2:0], 1'b0};
      quo_d = {quo_q[LenW-2:0], ge};
      cnt_d = cnt_q - QuoCntW'(1);
      if (cnt_q == QuoCntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
    quo_q <= quo_d;
  end

  assign stat_o.done     = done_q;
  assign stat_o.quotient = quo_q;

endmodule

### design/log_event_statistics_unit.sv
// Top level of the log event statistics unit: sequencing, window register, output register.
//
//   Port group    Direction  Handshake               Carries
//   in_item_i     input      in_valid_i / in_stall_o   one log event
//   out_item_o    output     out_valid_o / out_stall_i one statistics result
//   cfg_data_i    input      cfg_valid_i / cfg_ready_o window width in seconds
//
// One item at a time: an accept is followed by the pop loop, the serial divider and the load of
// the output register before the next accept is possible. The pop loop takes an extra read and
// compare when more than one timestamp remains after the push, and another for each dropped
// timestamp; a mean that saturates skips the 16 divider steps.
// Reset clears the counters and ring pointers and sets the window register to 3600 s.
// A result waits in the output register while a new item is accepted; a finished item
// waits for that register to empty when the output side stalls.
module log_event_statistics_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  lesu_pkg::event_t            in_item_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output lesu_pkg::result_t           out_item_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [lesu_pkg::TimeW-1:0]  cfg_data_i
);
  import lesu_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RING = 4'b0010,
    S_DIV  = 4'b0100,
    S_OUT  = 4'b1000
  } top_state_e;

  top_state_e        state_q, state_d;
  logic [TimeW-1:0]  window_q;
  logic              out_valid_q, out_valid_d;
  result_t           out_q;
  logic              accept;
  logic              load;
  logic              div_start;
  logic [CountW-1:0] divisor;
  stats_t            stats;
  ring_stat_t        ring_stat;
  div_stat_t         div_stat;

  assign accept      = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign divisor     = (stats.total_count == '0) ? CountW'(1) : stats.total_count;

  lesu_stats u_stats (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .upd_i   (accept),
    .item_i  (in_item_i),
    .stats_o (stats)
  );

  lesu_ring u_ring (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (accept),
    .ts_i     (in_item_i.timestamp),
    .window_i (window_q),
    .stat_o   (ring_stat)
  );

  lesu_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (stats.length_sum),
    .divisor_i  (divisor),
    .stat_o     (div_stat)
  );

  // Sequencer: ring pop loop, then the divider, then hand off to the output register.
  always_comb begin
    state_d     = state_q;
    div_start   = 1'b0;
    load        = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_RING;
        end
      end
      S_RING: begin
        if (ring_stat.done) begin
          div_start = 1'b1;
          state_d   = S_DIV;
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          load        = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      window_q    <= WindowReset;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        window_q <= cfg_data_i;
      end
    end
  end

  // Output register holds the finished item until it is taken.
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q.info_count      <= stats.info_count;
      out_q.warn_count      <= stats.warn_count;
      out_q.error_count     <= stats.error_count;
      out_q.total_count     <= stats.total_count;
      out_q.window_count    <= WinCntW'(ring_stat.fill);
      out_q.window_overflow <= ring_stat.overflow;
      out_q.longest         <= stats.longest;
      out_q.shortest        <= stats.shortest;
      out_q.mean_length     <= div_stat.quotient;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

### test/log_event_statistics_unit_tb.sv
// Self-checking testbench for the log event statistics unit: directed and random events.
`timescale 1ns / 1ps

module log_event_statistics_unit_tb;
  import lesu_pkg::*;

  // Level code that no counter tracks.
  localparam logic [1:0] LvlNone = 2'd3;
  localparam logic [LenW-1:0] LenMax = '1;
  localparam logic [TimeW-1:0] TimeMax = '1;

  // Receiver stall modes.
  typedef enum int unsigned {StallNone, StallRandom, StallPeriodic, StallHold} stall_mode_e;

  // Tracks the running statistics and the results that are still owed by the block.
  class log_stats_tracker;
    logic [TimeW-1:0]  window;
    logic [CountW-1:0] level_tally [3];
    logic [SumW-1:0]   length_sum;
    logic [LenW-1:0]   longest;
    logic [LenW-1:0]   shortest;
    logic [TimeW-1:0]  stamp_ring [WindowDepth];
    int unsigned       oldest;
    int unsigned       held;
    result_t           expected_stats [$];
    int unsigned       mismatch_count;

    function new();
      window = WindowReset;
      foreach (level_tally[i]) level_tally[i] = '0;
      length_sum = '0;
      longest = '0;
      shortest = LenMax;
      oldest = 0;
      held = 0;
      mismatch_count = 0;
    endfunction

    function logic [CountW-1:0] add_sat(logic [CountW-1:0] a, logic [CountW-1:0] b);
      logic [CountW:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[CountW] ? '1 : s[CountW-1:0];
    endfunction

    // Accepted event: update the statistics and queue the result it must produce.
    function void take_event(event_t ev);
      result_t           r;
      logic [SumW:0]     grown;
      logic [CountW-1:0] total;
      logic [CountW-1:0] divisor;
      logic [SumW-1:0]   quotient;
      r = '0;
      if (ev.level != LvlNone) level_tally[ev.level] = add_sat(level_tally[ev.level], 1);
      grown = {1'b0, length_sum} + (SumW+1)'(ev.message_length);
      length_sum = grown[SumW] ? '1 : grown[SumW-1:0];
      if (ev.message_length > longest) longest = ev.message_length;
      if (ev.message_length < shortest) shortest = ev.message_length;
      total = add_sat(add_sat(level_tally[LvlInfo], level_tally[LvlWarn]), level_tally[LvlError]);
      divisor = (total == '0) ? CountW'(1) : total;
      quotient = length_sum / SumW'(divisor);
      // A full ring loses its oldest entry before the push.
      if (held >= WindowDepth) begin
        oldest = (oldest + 1) % WindowDepth;
        held--;
        r.window_overflow = 1'b1;
      end
      stamp_ring[(oldest + held) % WindowDepth] = ev.timestamp;
      held++;
      // Age out old entries, but the newest one always stays.
      while (held > 1 && TimeW'(ev.timestamp - stamp_ring[oldest]) >= window) begin
        oldest = (oldest + 1) % WindowDepth;
        held--;
      end
      r.info_count   = level_tally[LvlInfo];
      r.warn_count   = level_tally[LvlWarn];
      r.error_count  = level_tally[LvlError];
      r.total_count  = total;
      r.window_count = WinCntW'(held);
      r.longest      = longest;
      r.shortest     = shortest;
      r.mean_length  = (quotient > SumW'(LenMax)) ? LenMax : quotient[LenW-1:0];
      expected_stats.push_back(r);
    endfunction

    function void check_field(string name, logic [CountW-1:0] want, logic [CountW-1:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatch_count++;
      end
    endfunction

    // Accepted result: compare with the oldest outstanding one.
    function void check_result(result_t got);
      result_t want;
      if (expected_stats.size() == 0) begin
        $error("result arrived with no event waiting for it");
        mismatch_count++;
        return;
      end
      want = expected_stats.pop_front();
      check_field("info_count", want.info_count, got.info_count);
      check_field("warn_count", want.warn_count, got.warn_count);
      check_field("error_count", want.error_count, got.error_count);
      check_field("total_count", want.total_count, got.total_count);
      check_field("window_count", CountW'(want.window_count), CountW'(got.window_count));
      check_field("window_overflow", CountW'(want.window_overflow),
                  CountW'(got.window_overflow));
      check_field("longest", CountW'(want.longest), CountW'(got.longest));
      check_field("shortest", CountW'(want.shortest), CountW'(got.shortest));
      check_field("mean_length", CountW'(want.mean_length), CountW'(got.mean_length));
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  event_t           in_item_i = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  result_t          out_item_o;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [TimeW-1:0] cfg_data_i = '0;

  log_stats_tracker tracker = new();
  logic [TimeW-1:0] stamp_now = '0;
  bit               long_hold_req = 1'b0;
  logic [1:0]       level_codes [3] = '{LvlInfo, LvlWarn, LvlError};

  log_event_statistics_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // Check every result item as it is taken.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) tracker.check_result(out_item_o);
  end

  // Receiver stall pattern, chosen segment by segment.
  initial begin : stall_pattern
    stall_mode_e mode;
    int unsigned span;
    int unsigned period;
    int unsigned pick;
    @(posedge rst_ni);
    forever begin
      pick = $urandom_range(0, 15);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        mode = StallHold;
      end else if (pick == 0) begin
        mode = StallHold;
      end else if (pick <= 5) begin
        mode = StallNone;
      end else if (pick <= 11) begin
        mode = StallRandom;
      end else begin
        mode = StallPeriodic;
      end
      span = (mode == StallHold) ? $urandom_range(200, 400) : $urandom_range(10, 80);
      period = $urandom_range(2, 5);
      for (int unsigned c = 0; c < span; c++) begin
        @(negedge clk_i);
        case (mode)
          StallNone:     out_stall_i <= 1'b0;
          StallRandom:   out_stall_i <= ($urandom_range(0, 1) == 1);
          StallPeriodic: out_stall_i <= (c % period == 0);
          default:       out_stall_i <= 1'b1;
        endcase
      end
    end
  end

  // Offer one event from a falling edge and return at the falling edge after it is taken.
  task automatic send_event(event_t ev);
    in_valid_i <= 1'b1;
    in_item_i <= ev;
    do @(posedge clk_i); while (in_stall_o);
    tracker.take_event(ev);
    @(negedge clk_i);
  endtask

  // Stop sending and wait until every outstanding result has come back.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (tracker.expected_stats.size() != 0) @(negedge clk_i);
    repeat (32) @(negedge clk_i);
  endtask

  // Change the window width while the block is idle.
  task automatic reconfigure_window(logic [TimeW-1:0] value);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    tracker.window = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic event_t make_event(logic [1:0] level, logic [LenW-1:0] len,
                                        logic [TimeW-1:0] stamp);
    event_t ev;
    ev.level = level;
    ev.message_length = len;
    ev.timestamp = stamp;
    return ev;
  endfunction

  // Mostly nondecreasing timestamps, with some jumps and some steps backwards.
  function automatic event_t random_event(int unsigned step_max);
    event_t      ev;
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) stamp_now = $urandom();
    else if (pick == 1) stamp_now = stamp_now - $urandom_range(1, 100);
    else stamp_now = stamp_now + $urandom_range(0, step_max);
    ev.timestamp = stamp_now;
    ev.level = ($urandom_range(0, 15) == 0) ? LvlNone : level_codes[$urandom_range(0, 2)];
    pick = $urandom_range(0, 15);
    if (pick == 0) ev.message_length = '0;
    else if (pick == 1) ev.message_length = LenMax;
    else ev.message_length = LenW'($urandom());
    return ev;
  endfunction

  // One random phase: set the window, then send events in bursts with gaps between them.
  task automatic run_phase(logic [TimeW-1:0] window, int unsigned count, int unsigned step_max,
                           bit force_hold);
    int unsigned sent;
    int unsigned burst;
    int unsigned gap;
    reconfigure_window(window);
    if (force_hold) long_hold_req = 1'b1;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 30);
      for (int unsigned k = 0; k < burst && sent < count; k++) begin
        send_event(random_event(step_max));
        sent++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
  endtask

  // Main sequence.
  initial begin : stimulus
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (4) @(negedge clk_i);

    // Reset window: mean with no counted level, mean saturation, extremes, wraparound ages.
    send_event(make_event(LvlNone, LenMax, 32'd0));
    send_event(make_event(LvlNone, LenMax, 32'd100));
    send_event(make_event(LvlInfo, '0, 32'd200));
    send_event(make_event(LvlWarn, 16'd1, 32'd3599));
    send_event(make_event(LvlError, LenMax, 32'd3600));
    send_event(make_event(LvlInfo, 16'd12345, TimeMax));
    send_event(make_event(LvlWarn, 16'd7, 32'd5));
    send_event(make_event(LvlError, 16'd300, 32'h8000_0000));
    send_event(make_event(LvlInfo, 16'h5555, 32'h7FFF_FFFF));
    send_event(make_event(LvlNone, 16'hAAAA, 32'h7FFF_FFFF));

    // Narrowest window: equal stamps stay, one second apart drops.
    reconfigure_window(32'd1);
    send_event(make_event(LvlWarn, 16'd50, 32'd50));
    send_event(make_event(LvlError, 16'd60, 32'd50));
    send_event(make_event(LvlInfo, 16'd70, 32'd51));
    send_event(make_event(LvlNone, 16'd0, 32'd51));

    // Widest window: only a step back of exactly one second ages out.
    reconfigure_window(TimeMax);
    send_event(make_event(LvlInfo, 16'd80, 32'd0));
    send_event(make_event(LvlWarn, 16'd90, 32'd50));
    send_event(make_event(LvlError, LenMax, 32'hFFFF_FFF0));

    // Random phases; the widest window fills the ring past its depth.
    run_phase(32'd1, 120, 2, 1'b0);
    run_phase(TimeW'($urandom_range(20, 2000)), 150, 50, 1'b0);
    run_phase(TimeMax, 1040, 1000, 1'b1);
    run_phase(32'd16, 40, 8, 1'b0);

    drain_results();
    repeat (64) @(negedge clk_i);
    if (tracker.mismatch_count == 0 && tracker.expected_stats.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Run limit.
  initial begin : watchdog
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
